// ----- rtl/core/hcrp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the HTTP closed byte-range parser.
// No dependencies; all other files reference it by scoped names.
package hcrp_pkg;

    localparam int unsigned DATA_W   = 64;
    localparam int unsigned ACC_EXT  = 4;   // headroom bits for acc * 10 + digit
    localparam int unsigned PREFIX_W = 3;

    localparam logic [PREFIX_W-1:0] PREFIX_BYTES = 3'd6;

    localparam logic [7:0] CH_DASH = 8'h2d;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [1:0] ST_ABSENT  = 2'd0;
    localparam logic [1:0] ST_VALID   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'b001,
        PH_START  = 3'b010,
        PH_END    = 3'b100
    } t_phase;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] range_start;
        logic [DATA_W-1:0] range_end;
    } t_verdict;

    // Expected byte at each position of the literal "bytes=".
    function automatic logic [7:0] prefix_char(input logic [PREFIX_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h62;  // b
            3'd1:    ch = 8'h79;  // y
            3'd2:    ch = 8'h74;  // t
            3'd3:    ch = 8'h65;  // e
            3'd4:    ch = 8'h73;  // s
            3'd5:    ch = 8'h3d;  // =
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/core/http_closed_range_parser_core.sv -----
`timescale 1ns / 1ps
// HTTP closed byte-range parser, top level: input register, parse stage, result register.
// An accepted end word's verdict is registered in the result register, which drives o_valid.
// Throughput: one word per cycle while o_stall is low; an end word stalls while
//   the result register is held; each accumulator update is a 68-bit multiply-by-ten add.
// Reset: synchronous, active low; clears the parse state and both valid flags.
// Depends on hcrp_pkg, hcrp_parse and hcrp_accum.
module http_closed_range_parser_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_kind,
    input  logic [7:0]                  i_char_byte,
    input  logic [hcrp_pkg::DATA_W-1:0] i_file_size,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_status,
    output logic [hcrp_pkg::DATA_W-1:0] o_range_start,
    output logic [hcrp_pkg::DATA_W-1:0] o_range_end
);

    // Input register: holds one word until the parse stage consumes it.
    logic                        r_in_valid;
    logic                        r_in_kind;
    logic [7:0]                  r_in_char;
    logic [hcrp_pkg::DATA_W-1:0] r_in_size;

    // Result register: parts the parse stage from the downstream stall.
    logic                        r_out_valid;
    logic [1:0]                  r_out_status;
    logic [hcrp_pkg::DATA_W-1:0] r_out_start;
    logic [hcrp_pkg::DATA_W-1:0] r_out_end;

    logic               out_free;
    logic               in_adv;
    hcrp_pkg::t_verdict verdict;

    // The result register can take a new word if empty or being drained this cycle.
    assign out_free = !r_out_valid || !i_stall;

    // Byte words never produce a result, so they advance regardless of the
    // result side; an end word waits for room in the result register.
    assign in_adv = r_in_valid && ((r_in_kind == hcrp_pkg::KIND_BYTE) || out_free);

    // Stall upstream only while a held word cannot advance.
    assign o_stall = r_in_valid && !in_adv;

    hcrp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_adv),
        .i_kind      (r_in_kind),
        .i_char_byte (r_in_char),
        .i_file_size (r_in_size),
        .o_verdict   (verdict)
    );

    // Input register: load a new word whenever the slot is empty or advancing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_kind <= i_kind;
            r_in_char <= i_char_byte;
            r_in_size <= i_file_size;
        end
    end

    // Result register: capture the verdict when an end word advances; hold
    // while downstream stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= in_adv && (r_in_kind == hcrp_pkg::KIND_END);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && in_adv && (r_in_kind == hcrp_pkg::KIND_END)) begin
            r_out_status <= verdict.status;
            r_out_start  <= verdict.range_start;
            r_out_end    <= verdict.range_end;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_range_start = r_out_start;
    assign o_range_end   = r_out_end;

endmodule

// ----- rtl/core/hcrp_accum.sv -----
`timescale 1ns / 1ps
// Decimal accumulate step: acc * 10 + digit with exact 64-bit overflow flag.
// Depends on hcrp_pkg.
module hcrp_accum (
    input  logic [hcrp_pkg::DATA_W-1:0] i_acc,
    input  logic [3:0]                  i_digit,
    output logic [hcrp_pkg::DATA_W-1:0] o_acc,
    output logic                        o_ovf
);

    localparam int unsigned WIDE_W = hcrp_pkg::DATA_W + hcrp_pkg::ACC_EXT;

    logic [WIDE_W-1:0] wide_acc;
    logic [WIDE_W-1:0] wide_sum;

    // acc * 10 as (acc << 3) + (acc << 1)
    assign wide_acc = {{hcrp_pkg::ACC_EXT{1'b0}}, i_acc};
    assign wide_sum = (wide_acc << 3) + (wide_acc << 1)
                    + {{(WIDE_W-4){1'b0}}, i_digit};

    assign o_acc = wide_sum[hcrp_pkg::DATA_W-1:0];
    assign o_ovf = |wide_sum[WIDE_W-1:hcrp_pkg::DATA_W];

endmodule

// ----- rtl/core/hcrp_parse.sv -----
`timescale 1ns / 1ps
// Parse state of one header value and the verdict formed on the end word.
// Depends on hcrp_pkg and hcrp_accum.
module hcrp_parse (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic                        i_kind,
    input  logic [7:0]                  i_char_byte,
    input  logic [hcrp_pkg::DATA_W-1:0] i_file_size,
    output hcrp_pkg::t_verdict          o_verdict
);

    hcrp_pkg::t_phase                r_phase,      n_phase;
    logic [hcrp_pkg::PREFIX_W-1:0]   r_prefix_pos, n_prefix_pos;
    logic                            r_bytes_seen, n_bytes_seen;
    logic [hcrp_pkg::DATA_W-1:0]     r_start_acc,  n_start_acc;
    logic [hcrp_pkg::DATA_W-1:0]     r_end_acc,    n_end_acc;
    logic                            r_start_dig,  n_start_dig;
    logic                            r_end_dig,    n_end_dig;
    logic                            r_failed,     n_failed;

    logic                            is_digit;
    logic [7:0]                      digit_byte;
    logic [3:0]                      digit;
    logic [hcrp_pkg::DATA_W-1:0]     start_step, end_step;
    logic                            start_ovf, end_ovf;

    assign is_digit   = (i_char_byte >= hcrp_pkg::CH_ZERO) && (i_char_byte <= hcrp_pkg::CH_NINE);
    assign digit_byte = i_char_byte - hcrp_pkg::CH_ZERO;
    assign digit      = digit_byte[3:0];

    hcrp_accum u_start_accum (
        .i_acc   (r_start_acc),
        .i_digit (digit),
        .o_acc   (start_step),
        .o_ovf   (start_ovf)
    );

    hcrp_accum u_end_accum (
        .i_acc   (r_end_acc),
        .i_digit (digit),
        .o_acc   (end_step),
        .o_ovf   (end_ovf)
    );

    // Verdict on the current state and the size carried by the end word.
    always_comb begin
        o_verdict.range_start = '0;
        o_verdict.range_end   = '0;
        if (!r_bytes_seen) begin
            o_verdict.status = hcrp_pkg::ST_ABSENT;
        end else if (r_failed || (r_phase != hcrp_pkg::PH_END) || !r_end_dig
                     || (i_file_size == '0) || (r_start_acc > r_end_acc)
                     || (r_end_acc >= i_file_size)) begin
            o_verdict.status = hcrp_pkg::ST_INVALID;
        end else begin
            o_verdict.status      = hcrp_pkg::ST_VALID;
            o_verdict.range_start = r_start_acc;
            o_verdict.range_end   = r_end_acc;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_prefix_pos = r_prefix_pos;
        n_bytes_seen = r_bytes_seen;
        n_start_acc  = r_start_acc;
        n_end_acc    = r_end_acc;
        n_start_dig  = r_start_dig;
        n_end_dig    = r_end_dig;
        n_failed     = r_failed;
        if (i_fire) begin
            if (i_kind == hcrp_pkg::KIND_END) begin
                // Return to the empty state for the next header value.
                n_phase      = hcrp_pkg::PH_PREFIX;
                n_prefix_pos = '0;
                n_bytes_seen = 1'b0;
                n_start_acc  = '0;
                n_end_acc    = '0;
                n_start_dig  = 1'b0;
                n_end_dig    = 1'b0;
                n_failed     = 1'b0;
            end else begin
                n_bytes_seen = 1'b1;
                if (!r_failed) begin
                    case (r_phase)
                        hcrp_pkg::PH_PREFIX: begin
                            if ((r_prefix_pos >= hcrp_pkg::PREFIX_BYTES)
                                || (i_char_byte != hcrp_pkg::prefix_char(r_prefix_pos))) begin
                                n_failed = 1'b1;
                            end else begin
                                n_prefix_pos = r_prefix_pos + 3'd1;
                                if (n_prefix_pos == hcrp_pkg::PREFIX_BYTES) begin
                                    n_phase = hcrp_pkg::PH_START;
                                end
                            end
                        end
                        hcrp_pkg::PH_START: begin
                            if (is_digit) begin
                                n_start_dig = 1'b1;
                                if (start_ovf) begin
                                    n_failed = 1'b1;
                                end else begin
                                    n_start_acc = start_step;
                                end
                            end else if ((i_char_byte == hcrp_pkg::CH_DASH) && r_start_dig) begin
                                n_phase = hcrp_pkg::PH_END;
                            end else begin
                                n_failed = 1'b1;
                            end
                        end
                        hcrp_pkg::PH_END: begin
                            if (is_digit) begin
                                n_end_dig = 1'b1;
                                if (end_ovf) begin
                                    n_failed = 1'b1;
                                end else begin
                                    n_end_acc = end_step;
                                end
                            end else begin
                                n_failed = 1'b1;
                            end
                        end
                        default: begin
                            n_failed = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= hcrp_pkg::PH_PREFIX;
            r_prefix_pos <= '0;
            r_bytes_seen <= 1'b0;
            r_start_acc  <= '0;
            r_end_acc    <= '0;
            r_start_dig  <= 1'b0;
            r_end_dig    <= 1'b0;
            r_failed     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_prefix_pos <= n_prefix_pos;
            r_bytes_seen <= n_bytes_seen;
            r_start_acc  <= n_start_acc;
            r_end_acc    <= n_end_acc;
            r_start_dig  <= n_start_dig;
            r_end_dig    <= n_end_dig;
            r_failed     <= n_failed;
        end
    end

endmodule
